/* rtl/core/assert_macros.svh */
// Assertion helper macros for the spline evaluator core.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CRSE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spline evaluator check failed");

// next-cycle implication
`define CRSE_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spline evaluator check failed");

`endif

/* rtl/core/crse_pkg.sv */
// Shared types and constants for the Catmull-Rom spline evaluator.
// No dependencies; imported by crse_lane and the top level.
package crse_pkg;

  localparam int MAX_POINTS = 32;
  localparam int PT_IDX_W   = 5;
  localparam int COUNT_W    = 6;
  localparam int FRAC_W     = 16;
  localparam int POS_W      = 21;
  localparam int COORD_W    = 16;
  localparam int SLOPE_W    = 18;
  localparam int NPTS       = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [SLOPE_W-1:0] slope_t;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_EVAL  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE   = 1'b1;

  localparam logic [COUNT_W-1:0] RESET_POINT_COUNT = 6'd5;
  localparam logic               RESET_LOOP_MODE   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LAUNCH,
    ST_CALC,
    ST_FINISH
  } state_t;

endpackage

/* rtl/core/crse_lane.sv */
// One coordinate lane: cubic position and slope by Horner steps on one 33x17 multiplier.
// Depends on crse_pkg.
module crse_lane (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [crse_pkg::FRAC_W-1:0] frac,
  input  crse_pkg::coord_t            pts [crse_pkg::NPTS],
  output logic                        done,
  output crse_pkg::coord_t            pos,
  output crse_pkg::slope_t            slope
);
  import crse_pkg::*;

  localparam int CO_W   = 20;   // s3, s2
  localparam int S1_W   = 17;
  localparam int OP_W   = 33;
  localparam int PROD_W = OP_W + FRAC_W + 1;
  localparam int AD_W   = 40;
  localparam int BH_W   = 26;
  localparam int SA_W   = 25;
  localparam int PA_W   = 43;

  // step names ALO..BHI give the operand fed to the multiplier in that step;
  // accumulation in a step uses the product of the step before
  localparam logic [3:0] STEP_M1   = 4'd0;
  localparam logic [3:0] STEP_AD   = 4'd1;
  localparam logic [3:0] STEP_ALO  = 4'd2;
  localparam logic [3:0] STEP_AHI  = 4'd3;
  localparam logic [3:0] STEP_DLO  = 4'd4;
  localparam logic [3:0] STEP_BLO  = 4'd5;
  localparam logic [3:0] STEP_DHI  = 4'd6;
  localparam logic [3:0] STEP_BHI  = 4'd7;
  localparam logic [3:0] STEP_PEND = 4'd8;
  localparam logic [3:0] STEP_DONE = 4'd9;

  logic                     running;
  logic [3:0]               step;
  logic [FRAC_W-1:0]        f;
  logic signed [CO_W-1:0]   s3, s2;
  logic signed [S1_W-1:0]   s1, k1;
  logic signed [CO_W-1:0]   q0, q1, q2, q3;
  logic signed [CO_W-1:0]   s3_next, s2_next;
  logic signed [S1_W-1:0]   s1_next, k1_next;
  logic signed [OP_W-1:0]   op;
  logic signed [PROD_W-1:0] prod;
  logic signed [AD_W-1:0]   a, d, m1x, s2x;
  logic [15:0]              alf_hi;
  logic [31:0]              b_lo;
  logic signed [BH_W-1:0]   b_hi;
  logic signed [SA_W-1:0]   s_acc;
  logic signed [PA_W-1:0]   p_acc;

  // basis coefficients: s3 = -p0+3p1-3p2+p3, s2 = 2p0-5p1+4p2-p3, s1 = p2-p0, k = 2p1+1
  always_comb begin
    q0 = $signed({{(CO_W-COORD_W){pts[0][COORD_W-1]}}, pts[0]});
    q1 = $signed({{(CO_W-COORD_W){pts[1][COORD_W-1]}}, pts[1]});
    q2 = $signed({{(CO_W-COORD_W){pts[2][COORD_W-1]}}, pts[2]});
    q3 = $signed({{(CO_W-COORD_W){pts[3][COORD_W-1]}}, pts[3]});
    s3_next = (q3 - q0) + (q1 - q2) + ((q1 - q2) <<< 1);
    s2_next = (q0 <<< 1) - (q1 <<< 2) - q1 + (q2 <<< 2) - q3;
    s1_next = $signed({pts[2][COORD_W-1], pts[2]}) - $signed({pts[0][COORD_W-1], pts[0]});
    k1_next = $signed({pts[1], 1'b1});
  end

  always_comb begin
    case (step)
      STEP_M1:  op = $signed({{(OP_W-CO_W){s3[CO_W-1]}}, s3});
      STEP_ALO: op = $signed({1'b0, a[31:0]});
      STEP_AHI: op = $signed({{(OP_W-8){a[AD_W-1]}}, a[AD_W-1:32]});
      STEP_DLO: op = $signed({1'b0, d[31:0]});
      STEP_BLO: op = $signed({1'b0, b_lo});
      STEP_DHI: op = $signed({{(OP_W-8){d[AD_W-1]}}, d[AD_W-1:32]});
      STEP_BHI: op = $signed({{(OP_W-BH_W){b_hi[BH_W-1]}}, b_hi});
      default:  op = '0;
    endcase
  end

  assign m1x = $signed(prod[AD_W-1:0]);
  assign s2x = $signed({{(AD_W-CO_W){s2[CO_W-1]}}, s2});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      step    <= STEP_M1;
    end else if (start) begin
      running <= 1'b1;
      step    <= STEP_M1;
    end else if (running) begin
      step <= step + 4'd1;
      if (step == STEP_DONE) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= op * $signed({1'b0, f});
    if (start) begin
      f  <= frac;
      s3 <= s3_next;
      s2 <= s2_next;
      s1 <= s1_next;
      k1 <= k1_next;
    end else if (running) begin
      case (step)
        STEP_AD: begin
          a <= m1x + (s2x <<< 16);
          d <= m1x + (m1x <<< 1) + (s2x <<< 17);
        end
        STEP_AHI: begin
          alf_hi <= prod[47:32];
          b_lo   <= prod[31:0];
        end
        STEP_DLO: begin
          // B = A*f + s1*2^32, kept as high word and low 32 bits
          b_hi <= $signed(prod[BH_W-1:0]) + $signed({{(BH_W-S1_W){s1[S1_W-1]}}, s1})
                  + $signed({{(BH_W-16){1'b0}}, alf_hi});
        end
        STEP_BLO: begin
          s_acc <= $signed({{(SA_W-16){1'b0}}, prod[47:32]})
                   + $signed({{(SA_W-S1_W){s1[S1_W-1]}}, s1}) + 25'sd1;
        end
        STEP_DHI: begin
          p_acc <= $signed({{(PA_W-16){1'b0}}, prod[47:32]})
                   + ($signed({{(PA_W-S1_W){k1[S1_W-1]}}, k1}) <<< 16);
        end
        STEP_BHI: begin
          s_acc <= s_acc + $signed(prod[SA_W-1:0]);
        end
        STEP_PEND: begin
          p_acc <= p_acc + $signed(prod[PA_W-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  assign done = running && (step == STEP_DONE);

  // position = p_acc >>> 17, slope = s_acc >>> 1, both saturated
  always_comb begin
    if (p_acc[PA_W-1:32] == {(PA_W-32){p_acc[PA_W-1]}}) begin
      pos = p_acc[32:17];
    end else if (p_acc[PA_W-1]) begin
      pos = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      pos = {1'b0, {(COORD_W-1){1'b1}}};
    end
    if (s_acc[SA_W-1:SLOPE_W] == {(SA_W-SLOPE_W){s_acc[SA_W-1]}}) begin
      slope = s_acc[SLOPE_W:1];
    end else if (s_acc[SA_W-1]) begin
      slope = {1'b1, {(SLOPE_W-1){1'b0}}};
    end else begin
      slope = {1'b0, {(SLOPE_W-1){1'b1}}};
    end
  end

endmodule

/* rtl/core/catmull_rom_spline_evaluator_unit.sv */
// Uniform Catmull-Rom spline evaluator: a 32-entry table of Q12.4 control points
// in one synchronous RAM (x and y in one word, one write port and one registered
// read port), two arithmetic lanes (crse_lane) for x and y. Depends on crse_pkg,
// assert_macros.svh. A write item goes into the table as it is accepted. An
// evaluate item occupies the block: it is accepted, the four neighbouring points
// are read through the single registered read port, the lanes are started and run
// their nine-step multiply sequence on one 33x17 multiplier each, and the output
// register is loaded. An item whose segment lies outside the points in use skips the
// table and the lanes and goes straight to the output register. A finished result
// waits in the output register while write items keep being accepted; config writes
// are always taken and must only arrive while no evaluate item is in flight.
`include "assert_macros.svh"

module catmull_rom_spline_evaluator_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            kind,
  input  logic [crse_pkg::PT_IDX_W-1:0]   point_index,
  input  crse_pkg::coord_t                point_x,
  input  crse_pkg::coord_t                point_y,
  input  logic [crse_pkg::POS_W-1:0]      curve_position,
  output logic                            out_valid,
  input  logic                            out_ready,
  output crse_pkg::coord_t                pos_x,
  output crse_pkg::coord_t                pos_y,
  output crse_pkg::slope_t                slope_x,
  output crse_pkg::slope_t                slope_y,
  output logic                            range_error,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [crse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crse_pkg::CFG_DATA_W-1:0] cfg_data
);
  import crse_pkg::*;

  localparam int WORD_W = 2 * COORD_W;

  state_t              state, state_next;
  logic [COUNT_W-1:0]  point_count;
  logic                loop_mode;
  logic                in_acc, lane_start, lane_done, done_x, done_y, load_out;
  logic [2:0]          fc;
  logic [FRAC_W-1:0]   frac;
  logic                err;
  logic [PT_IDX_W-1:0] idx [NPTS];
  logic [PT_IDX_W-1:0] idx_next [NPTS];
  logic                err_next;
  coord_t              pts_x [NPTS];
  coord_t              pts_y [NPTS];
  coord_t              lx_pos, ly_pos;
  slope_t              lx_slope, ly_slope;

  logic [WORD_W-1:0]   ctrl_mem [MAX_POINTS];
  logic [WORD_W-1:0]   rd_data;
  logic [PT_IDX_W-1:0] rd_addr;

  // neighbour index decode
  logic [COUNT_W-1:0]  n, sx, s1p, s2p;
  logic [PT_IDX_W-1:0] seg;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;

  always_comb begin
    n   = (point_count > COUNT_W'(MAX_POINTS)) ? COUNT_W'(MAX_POINTS) : point_count;
    seg = curve_position[POS_W-1:FRAC_W];
    sx  = {1'b0, seg};
    s1p = sx + 6'd1;
    s2p = sx + 6'd2;
    if (loop_mode) begin
      err_next    = (n == '0) || (sx >= n);
      idx_next[1] = seg;
      idx_next[2] = (s1p >= n) ? PT_IDX_W'(s1p - n) : s1p[PT_IDX_W-1:0];
      if (n == 6'd1) begin
        idx_next[3] = '0;
      end else if (s2p >= n) begin
        idx_next[3] = PT_IDX_W'(s2p - n);
      end else begin
        idx_next[3] = s2p[PT_IDX_W-1:0];
      end
      idx_next[0] = (seg == '0) ? PT_IDX_W'(n - 6'd1) : (seg - 5'd1);
    end else begin
      err_next    = ({1'b0, sx} + 7'd3) >= {1'b0, n};
      idx_next[0] = seg;
      idx_next[1] = seg + 5'd1;
      idx_next[2] = seg + 5'd2;
      idx_next[3] = seg + 5'd3;
    end
  end

  // control point table
  assign rd_addr = idx[fc[1:0]];

  always_ff @(posedge clk) begin
    if (in_acc && (kind == KIND_WRITE)) begin
      ctrl_mem[point_index] <= {point_x, point_y};
    end
    rd_data <= ctrl_mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    lane_start = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_acc && (kind == KIND_EVAL)) begin
          state_next = err_next ? ST_FINISH : ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (fc == 3'(NPTS)) begin
          state_next = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        lane_start = 1'b1;
        state_next = ST_CALC;
      end
      ST_CALC: begin
        if (lane_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      point_count <= RESET_POINT_COUNT;
      loop_mode   <= RESET_LOOP_MODE;
      out_valid   <= 1'b0;
      fc          <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_POINT_COUNT: point_count <= cfg_data;
          CFG_LOOP_MODE:   loop_mode   <= cfg_data[0];
          default: begin
          end
        endcase
      end
      fc <= (state == ST_FETCH) ? fc + 3'd1 : '0;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (kind == KIND_EVAL)) begin
      idx  <= idx_next;
      frac <= curve_position[FRAC_W-1:0];
      err  <= err_next;
    end
    // read data arrives in the cycle after its address; shift points in from the top
    if ((state == ST_FETCH) && (fc != '0)) begin
      for (int i = 0; i < NPTS - 1; i++) begin
        pts_x[i] <= pts_x[i+1];
        pts_y[i] <= pts_y[i+1];
      end
      pts_x[NPTS-1] <= rd_data[WORD_W-1:COORD_W];
      pts_y[NPTS-1] <= rd_data[COORD_W-1:0];
    end
    if (load_out) begin
      range_error <= err;
      pos_x       <= err ? '0 : lx_pos;
      pos_y       <= err ? '0 : ly_pos;
      slope_x     <= err ? '0 : lx_slope;
      slope_y     <= err ? '0 : ly_slope;
    end
  end

  crse_lane u_lane_x (
    .clk   (clk),
    .rst   (rst),
    .start (lane_start),
    .frac  (frac),
    .pts   (pts_x),
    .done  (done_x),
    .pos   (lx_pos),
    .slope (lx_slope)
  );

  crse_lane u_lane_y (
    .clk   (clk),
    .rst   (rst),
    .start (lane_start),
    .frac  (frac),
    .pts   (pts_y),
    .done  (done_y),
    .pos   (ly_pos),
    .slope (ly_slope)
  );

  assign lane_done = done_x && done_y;

  `CRSE_ASSERT_IMP(err_zero_payload, clk, rst, out_valid && range_error, pos_x == '0 && pos_y == '0 && slope_x == '0 && slope_y == '0)
  `CRSE_ASSERT_IMP(lanes_in_step, clk, rst, done_x || done_y, done_x && done_y && state == ST_CALC)
  `CRSE_ASSERT_NXT(eval_blocks_input, clk, rst, in_valid && in_ready && kind == KIND_EVAL, !in_ready)
  `CRSE_ASSERT_NXT(finish_waits_slot, clk, rst, state == ST_FINISH && out_valid && !out_ready, state == ST_FINISH)

endmodule

/* tb/tb_catmull_rom_spline_evaluator_unit.sv */
// Self-checking testbench for the Catmull-Rom spline evaluator: directed and random items,
// a local predictor of the point table and curve arithmetic, a scoreboard on the results.
// Depends on crse_pkg and catmull_rom_spline_evaluator_unit.
`timescale 1ns / 100ps

module tb_catmull_rom_spline_evaluator_unit;
  import crse_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 30;
  localparam int ITEMS_PER_CFG = 40;

  typedef struct packed {
    coord_t px;
    coord_t py;
    slope_t sx;
    slope_t sy;
    logic   err;
  } curve_result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic                  kind;
  logic [PT_IDX_W-1:0]   point_index;
  coord_t                point_x;
  coord_t                point_y;
  logic [POS_W-1:0]      curve_position;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  coord_t                pos_x;
  coord_t                pos_y;
  slope_t                slope_x;
  slope_t                slope_y;
  logic                  range_error;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor state
  coord_t                ctl_x [MAX_POINTS];
  coord_t                ctl_y [MAX_POINTS];
  logic [MAX_POINTS-1:0] written;
  logic [COUNT_W-1:0]    cnt_reg;
  logic                  loop_reg;
  curve_result_t         expected_curve_q [$];

  int          mismatches = 0;
  int          send_idle_pct;
  int          recv_idle_pct;
  int unsigned cycle_count = 0;

  catmull_rom_spline_evaluator_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .point_index    (point_index),
    .point_x        (point_x),
    .point_y        (point_y),
    .curve_position (curve_position),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .slope_x        (slope_x),
    .slope_y        (slope_y),
    .range_error    (range_error),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int points_in_use();
    return (cnt_reg > MAX_POINTS) ? MAX_POINTS : int'(cnt_reg);
  endfunction

  // Returns 1 on a range error, else 0 and the table entries P0..P3 of the segment in pts.
  function automatic logic locate_segment(input logic [4:0] seg,
                                          output logic [3:0][4:0] pts);
    int n;
    int s;
    n = points_in_use();
    s = int'(seg);
    pts = '0;
    if (loop_reg) begin
      if (n == 0 || s >= n) return 1'b1;
      pts[0] = (s == 0) ? 5'(n - 1) : 5'(s - 1);
      pts[1] = 5'(s);
      pts[2] = 5'((s + 1) % n);
      pts[3] = 5'((s + 2) % n);
    end else begin
      if (s + 3 >= n) return 1'b1;
      for (int k = 0; k < 4; k++) pts[k] = 5'(s + k);
    end
    return 1'b0;
  endfunction

  // Exact cubic and its derivative at t = frac / 2^16, rounded half up to Q.4, saturated.
  function automatic void axis_eval(input logic signed [95:0] p0, p1, p2, p3,
                                    input logic signed [95:0] frac,
                                    output coord_t pos, output slope_t slope);
    logic signed [95:0] c3, c2, c1, c0, acc;
    c3 = -p0 + 3 * p1 - 3 * p2 + p3;
    c2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    c1 = p2 - p0;
    c0 = 2 * p1;
    // curve value times two at scale 2^48; the halving folds into the shift
    acc = (c3 * frac * frac * frac + ((c2 * frac * frac) <<< 16) + ((c1 * frac) <<< 32)
           + ((c0 + 1) <<< 48)) >>> 49;
    pos = (acc > 32767) ? 16'sh7FFF : (acc < -32768) ? 16'sh8000 : acc[15:0];
    acc = (3 * c3 * frac * frac + ((2 * c2 * frac) <<< 16) + ((c1 + 1) <<< 32)) >>> 33;
    slope = (acc > 131071) ? 18'sh1FFFF : (acc < -131072) ? 18'sh20000 : acc[17:0];
  endfunction

  function automatic void apply_item(input logic k, input logic [4:0] idx,
                                     input coord_t x, input coord_t y,
                                     input logic [POS_W-1:0] cp);
    curve_result_t   r;
    logic [3:0][4:0] pts;
    if (k == KIND_WRITE) begin
      ctl_x[idx] = x;
      ctl_y[idx] = y;
      written[idx] = 1'b1;
    end else begin
      r = '0;
      if (locate_segment(cp[20:16], pts)) begin
        r.err = 1'b1;
      end else begin
        axis_eval(ctl_x[pts[0]], ctl_x[pts[1]], ctl_x[pts[2]], ctl_x[pts[3]],
                  cp[15:0], r.px, r.sx);
        axis_eval(ctl_y[pts[0]], ctl_y[pts[1]], ctl_y[pts[2]], ctl_y[pts[3]],
                  cp[15:0], r.py, r.sy);
      end
      expected_curve_q = {expected_curve_q, r};
    end
  endfunction

  function automatic void check_field(input string name,
                                      input logic signed [31:0] want, got);
    if (got !== want) begin
      $error("%s expected %0d actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // result side: random stalls, each accepted result against the oldest expectation
  always @(posedge clk) begin
    curve_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_curve_q.size() == 0) begin
          $error("result with nothing expected: pos_x %0d pos_y %0d",
                 $signed(pos_x), $signed(pos_y));
          mismatches++;
        end else begin
          want = expected_curve_q.pop_front();
          check_field("pos_x", $signed(want.px), $signed(pos_x));
          check_field("pos_y", $signed(want.py), $signed(pos_y));
          check_field("slope_x", $signed(want.sx), $signed(slope_x));
          check_field("slope_y", $signed(want.sy), $signed(slope_y));
          check_field("range_error", want.err, range_error);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Valid is left high on return; the next call or drain() drives it in the same step.
  task automatic send_item(input logic k, input logic [4:0] idx, input coord_t x,
                           input coord_t y, input logic [POS_W-1:0] cp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    kind           <= k;
    point_index    <= idx;
    point_x        <= x;
    point_y        <= y;
    curve_position <= cp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_item(k, idx, x, y, cp);
  endtask

  task automatic send_point(input logic [4:0] idx, input coord_t x, input coord_t y);
    send_item(KIND_WRITE, idx, x, y, POS_W'($urandom));
  endtask

  task automatic send_eval(input logic [4:0] seg, input logic [15:0] frac);
    send_item(KIND_EVAL, 5'($urandom), coord_t'($urandom), coord_t'($urandom), {seg, frac});
  endtask

  // stop sending, wait for every expected result, then let any write item settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_curve_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [COUNT_W-1:0] count, input logic loop);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_POINT_COUNT;
    cfg_data  <= count;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cnt_reg = count;
    cfg_index <= CFG_LOOP_MODE;
    cfg_data  <= CFG_DATA_W'(loop);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    loop_reg = loop;
    cfg_valid <= 1'b0;
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3, 4: return coord_t'($urandom_range(4095)) - 16'sd2048;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_frac();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // reset config is five points, closed: segments 5 and 31 lie outside
  task automatic test_range_error_at_reset();
    send_eval(5'd5, 16'h0000);
    send_eval(5'd31, 16'hFFFF);
  endtask

  task automatic test_point_extremes();
    send_point(5'd0, 16'sh7FFF, 16'sh8000);
    send_point(5'd1, 16'sh8000, 16'sh7FFF);
    send_point(5'd2, 16'sh7FFF, 16'sh7FFF);
    send_point(5'd3, 16'sh8000, 16'sh8000);
    send_point(5'd4, 16'sh0000, 16'sh0010);
    send_point(5'd30, -16'sd5, 16'sd1234);
    send_point(5'd31, 16'sh0A0A, -16'sh1234);
  endtask

  // first and last segment wrap around the end of the points in use
  task automatic test_closed_curve_segments();
    send_eval(5'd0, 16'h0000);
    send_eval(5'd0, 16'hFFFF);
    send_eval(5'd4, 16'h8000);
    send_eval(5'd2, 16'h0001);
    send_eval(5'd1, 16'h4000);
  endtask

  task automatic test_open_curve();
    set_config(6'd5, 1'b0);
    send_eval(5'd0, 16'h4000);
    send_eval(5'd1, 16'hFFFF);
    send_eval(5'd2, 16'h0000);
  endtask

  // zero points, a count above the table, the smallest open curve, too few points
  task automatic test_point_count_limits();
    set_config(6'd0, 1'b1);
    send_eval(5'd0, 16'h1234);
    set_config(6'd63, 1'b1);
    send_eval(5'd31, 16'hFFFF);
    set_config(6'd4, 1'b0);
    send_eval(5'd0, 16'hC000);
    set_config(6'd3, 1'b0);
    send_eval(5'd0, 16'h0001);
  endtask

  task automatic test_random_traffic(input int items, input int snd_pct, input int rcv_pct);
    int              n;
    int              missing;
    logic [4:0]      seg;
    logic [15:0]     frac;
    logic [3:0][4:0] pts;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    for (int i = 0; i < items; i++) begin
      if (i % ITEMS_PER_CFG == 0) begin
        case ($urandom_range(9))
          0:       set_config(6'($urandom_range(3)), 1'($urandom));
          1:       set_config(6'($urandom_range(63, 33)), 1'($urandom));
          2:       set_config(6'd32, 1'($urandom));
          3:       set_config(6'd4, 1'($urandom));
          default: set_config(6'($urandom_range(32, 4)), 1'($urandom));
        endcase
      end
      if ($urandom_range(99) < 35) begin
        send_point(5'($urandom), rand_coord(), rand_coord());
      end else begin
        n = points_in_use();
        frac = rand_frac();
        if ($urandom_range(99) < 15) seg = 5'($urandom);
        else if (loop_reg && n >= 1) seg = 5'($urandom_range(n - 1));
        else if (!loop_reg && n >= 4) seg = 5'($urandom_range(n - 4));
        else seg = 5'($urandom);
        // never read an entry that has not been written: fill it first
        missing = -1;
        if (!locate_segment(seg, pts)) begin
          for (int k = 3; k >= 0; k--) if (!written[pts[k]]) missing = pts[k];
        end
        if (missing >= 0) send_point(5'(missing), rand_coord(), rand_coord());
        else send_eval(seg, frac);
      end
    end
  endtask

  initial begin
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    kind           <= KIND_WRITE;
    point_index    <= '0;
    point_x        <= '0;
    point_y        <= '0;
    curve_position <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= CFG_POINT_COUNT;
    cfg_data       <= '0;
    cnt_reg  = RESET_POINT_COUNT;
    loop_reg = RESET_LOOP_MODE;
    written  = '0;
    send_idle_pct = 27;
    recv_idle_pct = 58;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_range_error_at_reset();
    test_point_extremes();
    test_closed_curve_segments();
    test_open_curve();
    test_point_count_limits();
    test_random_traffic(350, 27, 58);
    test_random_traffic(350, 58, 27);
    test_random_traffic(350, 0, 0);
    drain();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
